[rtl/home_distance_bearing_tracker_defines.svh]
// Assertion macros shared by the checker of home_distance_bearing_tracker.
// No dependencies; the user supplies clk_i and rst_ni in scope.
`ifndef HOME_DISTANCE_BEARING_TRACKER_DEFINES_SVH
`define HOME_DISTANCE_BEARING_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HDBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HDBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hdbt_pkg.sv]
// Package for home_distance_bearing_tracker: sequencer states, CORDIC request,
// fixed-point constants and the arctangent table. No dependencies.
`default_nettype none

package hdbt_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned XW = 36;
  localparam int unsigned ZW = 20;
  localparam int unsigned PW = 68;

  localparam logic [29:0] LatClamp   = 30'd900000000;
  localparam logic [31:0] RadScale   = 32'd125764227;
  localparam logic [31:0] DistScale  = 32'd29033590;
  localparam logic [31:0] DegScale   = 32'd3754936;
  localparam logic [35:0] CordicGain = 36'd652032874;
  localparam logic [16:0] AlphaMax   = 17'd102944;
  localparam logic [12:0] Recip360   = 13'd2913;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZMUL,
    ST_COS_GO,
    ST_COS_RUN,
    ST_AXMUL,
    ST_VEC_GO,
    ST_VEC_RUN,
    ST_DMUL,
    ST_AMUL,
    ST_BEAR,
    ST_ARROW
  } state_e;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_req_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] r;
    unique case (idx)
      5'd0:  r = 17'd51472;
      5'd1:  r = 17'd30386;
      5'd2:  r = 17'd16055;
      5'd3:  r = 17'd8150;
      5'd4:  r = 17'd4091;
      5'd5:  r = 17'd2047;
      5'd6:  r = 17'd1024;
      5'd7:  r = 17'd512;
      5'd8:  r = 17'd256;
      5'd9:  r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/hdbt_cordic.sv]
// Shared iterative CORDIC, rotation or vectoring mode, one step per cycle.
// Depends on hdbt_pkg.
`default_nettype none

module hdbt_cordic #(
  parameter int unsigned Steps = hdbt_pkg::CordicStepsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire hdbt_pkg::cordic_req_t           req_i,
  input  wire logic signed [hdbt_pkg::XW-1:0]  x0_i,
  input  wire logic signed [hdbt_pkg::XW-1:0]  y0_i,
  input  wire logic signed [hdbt_pkg::ZW-1:0]  z0_i,
  output logic                                 done_o,
  output logic signed [hdbt_pkg::XW-1:0]       x_o,
  output logic signed [hdbt_pkg::ZW-1:0]       z_o
);

  localparam int unsigned CntW = $clog2(Steps + 1);

  logic signed [hdbt_pkg::XW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [hdbt_pkg::ZW-1:0] z_q, z_d, at;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic run_q, run_d, vec_q, vec_d, done_q, done_d, cw;

  always_comb begin
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = $signed({{(hdbt_pkg::ZW-17){1'b0}}, hdbt_pkg::atan_q16(5'(cnt_q))});
    cw = vec_q ? (y_q > 0) : z_q[hdbt_pkg::ZW-1];
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    cnt_d = cnt_q;
    run_d = run_q;
    vec_d = vec_q;
    done_d = 1'b0;
    if (req_i.start) begin
      x_d = x0_i;
      y_d = y0_i;
      z_d = z0_i;
      cnt_d = '0;
      run_d = 1'b1;
      vec_d = req_i.vec_mode;
    end else if (run_q) begin
      if (cw) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Steps - 1)) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
      vec_q <= 1'b0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
      vec_q <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

[rtl/home_distance_bearing_tracker.sv]
// Home distance and bearing tracker: the first fix of type 2 or 3 latches home;
// every later fix yields distance home in meters and a 0..16 arrow relative to
// heading. Each item takes two runs of the shared CORDIC (cosine of home
// latitude, then vectoring) plus four passes through one shared registered
// multiplier. A fix before home is set gives its result in the next cycle.
// Input is not ready while an item is at work or a result waits.
// Depends on hdbt_pkg and hdbt_cordic.
`default_nettype none

module home_distance_bearing_tracker #(
  parameter int unsigned CORDIC_STEPS = hdbt_pkg::CordicStepsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [30:0] latitude_i,
  input  wire logic signed [31:0] longitude_i,
  input  wire logic [1:0]         fix_quality_i,
  input  wire logic [8:0]         heading_deg_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    home_valid_o,
  output logic [19:0]             distance_m_o,
  output logic [4:0]              arrow_index_o
);

  hdbt_pkg::state_e state_q, state_d;
  hdbt_pkg::cordic_req_t creq;

  logic home_set_q, out_valid_q, east_neg_q;
  logic signed [30:0] home_lat_q, lat_q;
  logic signed [31:0] home_lon_q, lon_q;
  logic [8:0] head_q, r_q;
  logic [19:0] dist_q;
  logic [4:0] arrow_q;
  logic [30:0] cos_q;
  logic [34:0] mag_q;
  logic [16:0] alpha_q;
  logic [hdbt_pkg::PW-1:0] prod_q;

  logic accept, cdone;
  logic [35:0] mul_a;
  logic [31:0] mul_b;
  logic [30:0] hl_abs;
  logic [29:0] lat_cl;
  logic signed [31:0] north;
  logic signed [32:0] dlon;
  logic [31:0] north_abs;
  logic [32:0] dlon_abs;
  logic [31:0] ax;
  logic [8:0] head_mod;
  logic signed [hdbt_pkg::XW-1:0] cx0, cy0, cx;
  logic signed [hdbt_pkg::ZW-1:0] cz0, cz;
  logic [hdbt_pkg::PW-1:0] zround;
  logic [22:0] adeg;
  logic signed [25:0] bq;
  logic signed [9:0] bdeg;
  logic signed [10:0] rdiff;
  logic [12:0] av;
  logic [25:0] aq;
  logic [4:0] idx;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == hdbt_pkg::ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign home_valid_o = home_set_q;
  assign distance_m_o = dist_q;
  assign arrow_index_o = arrow_q;

  always_comb begin
    hl_abs = home_lat_q[30] ? 31'(-home_lat_q) : 31'(home_lat_q);
    lat_cl = (hl_abs > 31'(hdbt_pkg::LatClamp)) ? hdbt_pkg::LatClamp : hl_abs[29:0];
    north = $signed({home_lat_q[30], home_lat_q}) - $signed({lat_q[30], lat_q});
    dlon = $signed({home_lon_q[31], home_lon_q}) - $signed({lon_q[31], lon_q});
    north_abs = north[31] ? 32'(-north) : 32'(north);
    dlon_abs = dlon[32] ? 33'(-dlon) : 33'(dlon);
    ax = prod_q[61:30];
    head_mod = (heading_deg_i >= 9'd360) ? heading_deg_i - 9'd360 : heading_deg_i;
    zround = prod_q + (68'd1 << 39);
    cz0 = (state_q == hdbt_pkg::ST_COS_GO) ? hdbt_pkg::ZW'(zround >> 40) : '0;
    cx0 = (state_q == hdbt_pkg::ST_COS_GO) ? $signed(hdbt_pkg::CordicGain)
                                           : $signed({4'b0, north_abs});
    cy0 = (state_q == hdbt_pkg::ST_COS_GO) ? '0 : $signed({4'b0, ax});
    adeg = prod_q[38:16];
    priority if (!north[31] && !east_neg_q) bq = $signed({3'b0, adeg});
    else if (north[31] && !east_neg_q) bq = 26'sd11796480 - $signed({3'b0, adeg});
    else if (north[31]) bq = 26'sd11796480 + $signed({3'b0, adeg});
    else bq = 26'sd23592960 - $signed({3'b0, adeg});
    bdeg = bq[25:16];
    if (bdeg >= 10'sd360) bdeg = bdeg - 10'sd360;
    if (bdeg < 0) bdeg = '0;
    rdiff = $signed({bdeg[9], bdeg}) - $signed({2'b0, head_q});
    if (rdiff < 0) rdiff = rdiff + 11'sd360;
    av = {r_q, 4'b0} + 13'd180;
    aq = 26'(av) * 26'(hdbt_pkg::Recip360);
    idx = aq[24:20] + 5'd1;
    if (idx > 5'd16) idx = '0;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      hdbt_pkg::ST_ZMUL: begin
        mul_a = 36'(lat_cl);
        mul_b = hdbt_pkg::RadScale;
      end
      hdbt_pkg::ST_AXMUL: begin
        mul_a = 36'(dlon_abs);
        mul_b = 32'(cos_q);
      end
      hdbt_pkg::ST_DMUL: begin
        mul_a = 36'(mag_q);
        mul_b = hdbt_pkg::DistScale;
      end
      hdbt_pkg::ST_AMUL: begin
        mul_a = 36'(alpha_q);
        mul_b = hdbt_pkg::DegScale;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    creq = '0;
    unique case (state_q)
      hdbt_pkg::ST_IDLE:
        if (accept && home_set_q) state_d = hdbt_pkg::ST_ZMUL;
      hdbt_pkg::ST_ZMUL: state_d = hdbt_pkg::ST_COS_GO;
      hdbt_pkg::ST_COS_GO: begin
        creq.start = 1'b1;
        state_d = hdbt_pkg::ST_COS_RUN;
      end
      hdbt_pkg::ST_COS_RUN:
        if (cdone) state_d = hdbt_pkg::ST_AXMUL;
      hdbt_pkg::ST_AXMUL: state_d = hdbt_pkg::ST_VEC_GO;
      hdbt_pkg::ST_VEC_GO: begin
        creq.start = 1'b1;
        creq.vec_mode = 1'b1;
        state_d = hdbt_pkg::ST_VEC_RUN;
      end
      hdbt_pkg::ST_VEC_RUN:
        if (cdone) state_d = hdbt_pkg::ST_DMUL;
      hdbt_pkg::ST_DMUL: state_d = hdbt_pkg::ST_AMUL;
      hdbt_pkg::ST_AMUL: state_d = hdbt_pkg::ST_BEAR;
      hdbt_pkg::ST_BEAR: state_d = hdbt_pkg::ST_ARROW;
      hdbt_pkg::ST_ARROW: state_d = hdbt_pkg::ST_IDLE;
      default: state_d = hdbt_pkg::ST_IDLE;
    endcase
  end

  hdbt_cordic #(
    .Steps(CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (creq),
    .x0_i  (cx0),
    .y0_i  (cy0),
    .z0_i  (cz0),
    .done_o(cdone),
    .x_o   (cx),
    .z_o   (cz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hdbt_pkg::ST_IDLE;
      home_set_q <= 1'b0;
      home_lat_q <= '0;
      home_lon_q <= '0;
      dist_q <= '0;
      arrow_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (accept && !home_set_q) begin
        out_valid_q <= 1'b1;
        if (fix_quality_i > 2'd1) begin
          home_set_q <= 1'b1;
          home_lat_q <= latitude_i;
          home_lon_q <= longitude_i;
        end
      end
      if (state_q == hdbt_pkg::ST_AMUL) begin
        dist_q <= (|prod_q[67:52]) ? '1 : prod_q[51:32];
      end
      if (state_q == hdbt_pkg::ST_ARROW) begin
        arrow_q <= idx;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {32'b0, mul_a} * {36'b0, mul_b};
    if (accept) begin
      lat_q <= latitude_i;
      lon_q <= longitude_i;
      head_q <= head_mod;
    end
    if (state_q == hdbt_pkg::ST_COS_RUN && cdone) begin
      if (cx < 0) cos_q <= '0;
      else if (cx > $signed(36'd1 << 30)) cos_q <= 31'd1 << 30;
      else cos_q <= cx[30:0];
    end
    if (state_q == hdbt_pkg::ST_VEC_GO) east_neg_q <= dlon[32] && (ax != 32'd0);
    if (state_q == hdbt_pkg::ST_VEC_RUN && cdone) begin
      mag_q <= (cx < 0) ? '0 : cx[34:0];
      if (cz < 0) alpha_q <= '0;
      else if (cz > $signed(20'(hdbt_pkg::AlphaMax))) alpha_q <= hdbt_pkg::AlphaMax;
      else alpha_q <= cz[16:0];
    end
    if (state_q == hdbt_pkg::ST_BEAR) r_q <= rdiff[8:0];
  end

endmodule

`default_nettype wire

[rtl/hdbt_checker.sv]
// Port-level checker for home_distance_bearing_tracker, bound to the top level.
// Depends on home_distance_bearing_tracker_defines.svh.
`default_nettype none
`include "home_distance_bearing_tracker_defines.svh"

module hdbt_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               home_valid_o,
  input wire logic [19:0]        distance_m_o,
  input wire logic [4:0]         arrow_index_o
);

  `HDBT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(distance_m_o) && $stable(arrow_index_o), "result item changed while stalled")
  `HDBT_ASSERT_NOW(a_one_item, in_ready_o, !out_valid_o, "input ready while a result item waits")
  `HDBT_ASSERT_NEXT(a_home_sticky, home_valid_o, home_valid_o, "home point was lost")
  `HDBT_ASSERT_NOW(a_no_home_zero, out_valid_o && !home_valid_o, (distance_m_o == 20'd0) && (arrow_index_o == 5'd0), "nonzero result item before home")
  `HDBT_ASSERT_NOW(a_arrow_range, out_valid_o, arrow_index_o <= 5'd16, "arrow index out of range")

endmodule

bind home_distance_bearing_tracker hdbt_checker u_hdbt_checker (.*);

`default_nettype wire
